### hdl/ohsp_pkg.sv
// Package for the OBEX header stream parser: parse phases, header kind
// codes, length constants and the result record type. No dependencies.
package ohsp_pkg;

  typedef enum logic [1:0] {
    PH_ID      = 2'd0,
    PH_LEN_HI  = 2'd1,
    PH_LEN_LO  = 2'd2,
    PH_CONTENT = 2'd3
  } phase_e;

  // Top two bits of the header ID
  localparam logic [1:0] KIND_ONE_BYTE  = 2'b10;
  localparam logic [1:0] KIND_FOUR_BYTE = 2'b11;

  localparam logic [15:0] LEN_ONE_BYTE  = 16'd1;
  localparam logic [15:0] LEN_FOUR_BYTE = 16'd4;
  // ID byte plus two length bytes
  localparam logic [15:0] HDR_OVERHEAD  = 16'd3;

  typedef struct packed {
    logic [7:0]  header_id;
    logic [7:0]  content_byte;
    logic        content_valid;
    logic [15:0] content_offset;
    logic [15:0] content_length;
    logic        header_end;
    logic        area_done;
    logic        parse_error;
  } res_t;

endpackage

### hdl/obex_header_stream_parser.sv
// OBEX header stream parser top level: per-byte parse state, result
// register and skid stage. Depends on ohsp_pkg.
//
//  channel  direction  handshake                  payload
//  -------  ---------  -------------------------  ---------------------------------
//  in       sink       in_valid_i / in_stall_o    data_byte_i, area_first_i,
//                                                 area_last_i
//  out      source     out_valid_o / out_stall_i  header_id_o, content_byte_o,
//                                                 content_valid_o, content_offset_o,
//                                                 content_length_o, header_end_o,
//                                                 area_done_o, parse_error_o
//
// One byte per cycle while in_stall_o is low; a request's result, if any, is
// registered in the result register, or in the skid if that is held. The
// per-byte parse update is a single combinational step off the state registers.
// Two output entries let one result wait; in_stall_o rises only when both are full.
// rst_ni (async, active low) returns the parse to "expect header ID", clears
// the error hold and empties both output entries.
module obex_header_stream_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        area_first_i,
  input  logic        area_last_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  header_id_o,
  output logic [7:0]  content_byte_o,
  output logic        content_valid_o,
  output logic [15:0] content_offset_o,
  output logic [15:0] content_length_o,
  output logic        header_end_o,
  output logic        area_done_o,
  output logic        parse_error_o
);

  // ---------------------------------------------------------------
  // Parse state
  // ---------------------------------------------------------------
  ohsp_pkg::phase_e phase_q, phase_d;
  logic [7:0]  cur_id_q, cur_id_d;
  logic [7:0]  len_hi_q, len_hi_d;
  logic [15:0] total_q, total_d;
  logic [15:0] count_q, count_d;
  logic        err_q, err_d;

  // Output entries
  logic           out_vld_q, skid_vld_q;
  ohsp_pkg::res_t out_q, skid_q;

  logic           in_acc;
  logic           out_fire;
  logic           has_res;
  ohsp_pkg::res_t res;

  // Working values of the combinational step
  ohsp_pkg::phase_e ph_eff;
  logic        err_eff;
  logic [15:0] len_field;
  logic [15:0] len_content;
  logic [15:0] count_inc;

  assign in_stall_o = skid_vld_q;
  assign in_acc     = in_valid_i && !skid_vld_q;
  assign out_fire   = out_vld_q && !out_stall_i;

  assign len_field   = {len_hi_q, data_byte_i};
  assign len_content = len_field - ohsp_pkg::HDR_OVERHEAD;
  assign count_inc   = count_q + 16'd1;

  // Next parse state and result for the byte on the input
  always_comb begin
    ph_eff  = area_first_i ? ohsp_pkg::PH_ID : phase_q;
    err_eff = area_first_i ? 1'b0 : err_q;

    phase_d  = ph_eff;
    err_d    = err_eff;
    cur_id_d = cur_id_q;
    len_hi_d = len_hi_q;
    total_d  = total_q;
    count_d  = count_q;
    res      = '0;
    has_res  = 1'b0;

    if (!err_eff) begin
      case (ph_eff)
        ohsp_pkg::PH_ID: begin
          cur_id_d = data_byte_i;
          count_d  = '0;
          case (data_byte_i[7:6])
            ohsp_pkg::KIND_ONE_BYTE: begin
              total_d = ohsp_pkg::LEN_ONE_BYTE;
              phase_d = ohsp_pkg::PH_CONTENT;
            end
            ohsp_pkg::KIND_FOUR_BYTE: begin
              total_d = ohsp_pkg::LEN_FOUR_BYTE;
              phase_d = ohsp_pkg::PH_CONTENT;
            end
            default: begin
              total_d = '0;
              phase_d = ohsp_pkg::PH_LEN_HI;
            end
          endcase
          if (area_last_i) begin
            // area ends right after an ID byte: truncated
            res.header_id   = data_byte_i;
            res.parse_error = 1'b1;
            has_res         = 1'b1;
            err_d           = 1'b1;
            phase_d         = ohsp_pkg::PH_ID;
          end
        end

        ohsp_pkg::PH_LEN_HI: begin
          len_hi_d = data_byte_i;
          phase_d  = ohsp_pkg::PH_LEN_LO;
          if (area_last_i) begin
            res.header_id   = cur_id_q;
            res.parse_error = 1'b1;
            has_res         = 1'b1;
            err_d           = 1'b1;
            phase_d         = ohsp_pkg::PH_ID;
          end
        end

        ohsp_pkg::PH_LEN_LO: begin
          if (len_field < ohsp_pkg::HDR_OVERHEAD) begin
            // length field cannot cover its own ID and length bytes
            res.header_id   = cur_id_q;
            res.parse_error = 1'b1;
            has_res         = 1'b1;
            err_d           = 1'b1;
            phase_d         = ohsp_pkg::PH_ID;
          end else begin
            total_d = len_content;
            count_d = '0;
            if (len_content == '0) begin
              // empty header closes on its length byte
              res.header_id  = cur_id_q;
              res.header_end = 1'b1;
              res.area_done  = area_last_i;
              has_res        = 1'b1;
              phase_d        = ohsp_pkg::PH_ID;
            end else if (area_last_i) begin
              res.header_id   = cur_id_q;
              res.parse_error = 1'b1;
              has_res         = 1'b1;
              err_d           = 1'b1;
              phase_d         = ohsp_pkg::PH_ID;
            end else begin
              phase_d = ohsp_pkg::PH_CONTENT;
            end
          end
        end

        ohsp_pkg::PH_CONTENT: begin
          if ((count_inc < total_q) && area_last_i) begin
            // area ends before the header's content is complete
            res.header_id   = cur_id_q;
            res.parse_error = 1'b1;
            has_res         = 1'b1;
            err_d           = 1'b1;
            phase_d         = ohsp_pkg::PH_ID;
          end else begin
            res.header_id      = cur_id_q;
            res.content_byte   = data_byte_i;
            res.content_valid  = 1'b1;
            res.content_offset = count_q;
            res.content_length = total_q;
            has_res            = 1'b1;
            count_d            = count_inc;
            if (count_inc >= total_q) begin
              res.header_end = 1'b1;
              res.area_done  = area_last_i;
              phase_d        = ohsp_pkg::PH_ID;
            end
          end
        end

        default: begin
          phase_d = ohsp_pkg::PH_ID;
        end
      endcase
    end
  end

  // Parse state registers: move only on an accepted request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= ohsp_pkg::PH_ID;
      err_q    <= 1'b0;
      cur_id_q <= '0;
      len_hi_q <= '0;
      total_q  <= '0;
      count_q  <= '0;
    end else if (in_acc) begin
      phase_q  <= phase_d;
      err_q    <= err_d;
      cur_id_q <= cur_id_d;
      len_hi_q <= len_hi_d;
      total_q  <= total_d;
      count_q  <= count_d;
    end
  end

  // Output entry valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (skid_vld_q) begin
      // input is held; drain skid into the result register
      if (out_fire) begin
        skid_vld_q <= 1'b0;
      end
    end else if (in_acc && has_res) begin
      if (out_vld_q && !out_fire) begin
        skid_vld_q <= 1'b1;
      end else begin
        out_vld_q <= 1'b1;
      end
    end else if (out_fire) begin
      out_vld_q <= 1'b0;
    end
  end

  // Output entry payloads
  always_ff @(posedge clk_i) begin
    if (skid_vld_q) begin
      if (out_fire) begin
        out_q <= skid_q;
      end
    end else if (in_acc && has_res) begin
      if (out_vld_q && !out_fire) begin
        skid_q <= res;
      end else begin
        out_q <= res;
      end
    end
  end

  assign out_valid_o      = out_vld_q;
  assign header_id_o      = out_q.header_id;
  assign content_byte_o   = out_q.content_byte;
  assign content_valid_o  = out_q.content_valid;
  assign content_offset_o = out_q.content_offset;
  assign content_length_o = out_q.content_length;
  assign header_end_o     = out_q.header_end;
  assign area_done_o      = out_q.area_done;
  assign parse_error_o    = out_q.parse_error;

  // ---------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------
  // skid entry is only ever filled behind a full result register
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid entry valid with empty result register");

  // an error result never carries content
  a_err_no_content: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && parse_error_o |-> !content_valid_o && !header_end_o)
    else $error("error result carries content or header end");

  // clean area end always coincides with a header end
  a_done_with_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && area_done_o |-> header_end_o)
    else $error("area_done without header_end");

  // content offset stays inside the header content
  a_offset_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && content_valid_o |-> content_offset_o < content_length_o)
    else $error("content offset beyond content length");

endmodule
